// ----- rtl/cq_pkg.sv -----
// Package: shared types, constants and helpers for the circular queue with find-and-rotate.
package cq_pkg;

    localparam int DEPTH = 128;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic signed [31:0] t_key;
    typedef logic [CNT_W-1:0]   t_cnt;

    typedef enum logic [1:0] {
        OP_ENQ  = 2'd0,
        OP_DEQ  = 2'd1,
        OP_FIND = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // Control for one cell of the chain.
    typedef struct packed {
        logic load;
        logic shift;
    } t_cell_ctl;

    // Counts leave the block masked to eight bits.
    function automatic logic [7:0] to_out8(input t_cnt v);
        logic [CNT_W+7:0] w;
        begin
            w = {8'd0, v};
            return w[7:0];
        end
    endfunction

endpackage

// ----- rtl/cq_in_if.sv -----
// Interface: request channel carrying an operation and a key.
interface cq_in_if;
    logic             valid;
    logic             ready;
    logic [1:0]       op;
    logic signed [31:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- rtl/cq_out_if.sv -----
// Interface: result channel carrying status, value and counts.
interface cq_out_if;
    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic signed [31:0] value;
    logic [7:0]       moved;
    logic [7:0]       fill;

    modport source (output valid, output status, output value, output moved, output fill,
                    input ready);
    modport sink   (input valid, input status, input value, input moved, input fill,
                     output ready);
endinterface

// ----- rtl/circular_queue_find_rotate.sv -----
// Top level: circular queue of signed keys held in a chain of cells, with find-and-rotate.
//
//  Channel  Dir  Payload                      Transfer when
//  i_in     in   op[1:0], key[31:0]           i_in.valid && i_in.ready
//  o_res    out  status, value, moved, fill   o_res.valid && o_res.ready
//
// Enqueue, dequeue and the unused code finish in the cycle of their transfer.
// A find makes one head comparison per cycle and rotates each mismatch to the tail,
// until a match is removed from the head or every entry has cycled; input is held off.
// The head is always cell 0; on a dequeue, removal or rotation the chain shifts left one cell per cycle.
// A synchronous reset empties the queue; cell contents are not cleared.
// A result waits in the output register; a new request is taken while it drains.
module circular_queue_find_rotate (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cq_in_if.sink     i_in,
    cq_out_if.source  o_res
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    cq_pkg::t_cnt r_fill, n_fill;
    cq_pkg::t_cnt r_remain, n_remain;
    cq_pkg::t_cnt r_moved, n_moved;
    cq_pkg::t_key r_key, n_key;

    logic           r_out_valid, n_out_valid;
    cq_pkg::t_status r_status, n_status;
    cq_pkg::t_key   r_value, n_value;
    logic [7:0]     r_out_moved, n_out_moved;
    logic [7:0]     r_out_fill, n_out_fill;

    cq_pkg::t_key w_val [cq_pkg::DEPTH];
    cq_pkg::t_key w_ext;
    cq_pkg::t_key w_head;
    cq_pkg::t_op  w_op;

    logic w_in_go, w_enq_go, w_deq_go, w_rot_go, w_rem_go, w_full;

    assign w_head = w_val[0];
    assign w_op   = cq_pkg::t_op'(i_in.op);
    assign w_full = (r_fill == cq_pkg::t_cnt'(cq_pkg::DEPTH));

    // A request is taken while idle and the output register is free or draining.
    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_res.ready);
    assign w_in_go    = i_in.valid && i_in.ready;

    // Chain operations for this cycle.
    assign w_enq_go = w_in_go && (w_op == cq_pkg::OP_ENQ) && !w_full;
    assign w_deq_go = w_in_go && (w_op == cq_pkg::OP_DEQ) && (r_fill != '0);
    assign w_rot_go = (r_state == S_SEARCH) && (r_remain != '0) && (w_head != r_key);
    assign w_rem_go = (r_state == S_SEARCH) && (r_remain != '0) && (w_head == r_key);

    // The shared bus carries the new key, or the head when it wraps to the tail.
    assign w_ext = (r_state == S_SEARCH) ? w_head : i_in.key;

    // The chain of cells, head at index 0.
    for (genvar i = 0; i < cq_pkg::DEPTH; i++) begin : g_cell
        cq_pkg::t_cell_ctl w_ctl;
        cq_pkg::t_key      w_next;

        assign w_ctl.load  = (w_enq_go && (r_fill == cq_pkg::t_cnt'(i)))
                          || (w_rot_go && (r_fill == cq_pkg::t_cnt'(i + 1)));
        assign w_ctl.shift = w_deq_go || w_rem_go || w_rot_go;

        if (i == cq_pkg::DEPTH - 1) begin : g_last
            assign w_next = w_val[i];
        end else begin : g_mid
            assign w_next = w_val[i + 1];
        end

        cq_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_ext   (w_ext),
            .i_next  (w_next),
            .o_value (w_val[i])
        );
    end

    // Sequencer and result formation.
    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_moved     = r_moved;
        n_key       = r_key;
        n_out_valid = r_out_valid && !o_res.ready;
        n_status    = r_status;
        n_value     = r_value;
        n_out_moved = r_out_moved;
        n_out_fill  = r_out_fill;

        case (r_state)
            S_IDLE: begin
                if (w_in_go) begin
                    n_status    = cq_pkg::ST_OK;
                    n_value     = '0;
                    n_out_moved = '0;
                    n_out_fill  = cq_pkg::to_out8(r_fill);
                    case (w_op)
                        cq_pkg::OP_ENQ: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_status = cq_pkg::ST_FULL;
                            end else begin
                                n_fill     = r_fill + 1'b1;
                                n_out_fill = cq_pkg::to_out8(r_fill + 1'b1);
                            end
                        end
                        cq_pkg::OP_DEQ: begin
                            n_out_valid = 1'b1;
                            if (r_fill == '0) begin
                                n_status = cq_pkg::ST_EMPTY;
                            end else begin
                                n_value    = w_head;
                                n_fill     = r_fill - 1'b1;
                                n_out_fill = cq_pkg::to_out8(r_fill - 1'b1);
                            end
                        end
                        cq_pkg::OP_FIND: begin
                            n_state  = S_SEARCH;
                            n_key    = i_in.key;
                            n_remain = r_fill;
                            n_moved  = '0;
                        end
                        default: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                if (r_remain == '0) begin
                    // Every entry has cycled once without a match.
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_status    = cq_pkg::ST_NOT_FOUND;
                    n_value     = '0;
                    n_out_moved = cq_pkg::to_out8(r_moved);
                    n_out_fill  = cq_pkg::to_out8(r_fill);
                end else if (w_head == r_key) begin
                    n_state     = S_IDLE;
                    n_fill      = r_fill - 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = cq_pkg::ST_OK;
                    n_value     = w_head;
                    n_out_moved = cq_pkg::to_out8(r_moved);
                    n_out_fill  = cq_pkg::to_out8(r_fill - 1'b1);
                end else begin
                    n_remain = r_remain - 1'b1;
                    n_moved  = r_moved + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_remain    <= '0;
            r_moved     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_remain    <= n_remain;
            r_moved     <= n_moved;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_status    <= n_status;
        r_value     <= n_value;
        r_out_moved <= n_out_moved;
        r_out_fill  <= n_out_fill;
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.status = r_status;
    assign o_res.value  = r_value;
    assign o_res.moved  = r_out_moved;
    assign o_res.fill   = r_out_fill;

endmodule

// ----- rtl/cq_cell.sv -----
// Module: one storage cell of the queue chain.
module cq_cell (
    input  logic              i_clk,
    input  cq_pkg::t_cell_ctl i_ctl,
    input  cq_pkg::t_key      i_ext,
    input  cq_pkg::t_key      i_next,
    output cq_pkg::t_key      o_value
);

    cq_pkg::t_key r_value;
    cq_pkg::t_key n_value;

    // A load from the shared bus wins over a shift from the right-hand neighbour.
    always_comb begin
        n_value = r_value;
        if (i_ctl.load) begin
            n_value = i_ext;
        end else if (i_ctl.shift) begin
            n_value = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule
